@@ rtl/atx_power_button_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// atx power button sequencer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ATX_POWER_BUTTON_SEQUENCER_MACROS_SVH
`define ATX_POWER_BUTTON_SEQUENCER_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define ATX_PBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atx_pbs: assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define ATX_PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atx_pbs: assertion failed");

`endif

@@ rtl/atx_pbs_pkg.sv @@
// ----------------------------------------------------------------------------
// atx power button sequencer package
// shared types, register indexes and reset defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atx_pbs_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_POWER_GOOD_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_BLINK_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_BLINK_TICKS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_PULSE_TICKS  = 3'd5;

    localparam logic [7:0] RST_POWER_GOOD_DELAY   = 8'd36;
    localparam logic [9:0] RST_HOLD_LIMIT         = 10'd108;
    localparam logic [7:0] RST_BLINK_PERIOD       = 8'd4;
    localparam logic [7:0] RST_RESET_BLINK_PERIOD = 8'd2;
    localparam logic [7:0] RST_RESET_BLINK_TICKS  = 8'd20;
    localparam logic [7:0] RST_RESET_PULSE_TICKS  = 8'd4;

    localparam logic [9:0] HELD_MAX = 10'd1023;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_FLASH = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] power_good_delay;
        logic [9:0] hold_limit;
        logic [7:0] blink_period;
        logic [7:0] reset_blink_period;
        logic [7:0] reset_blink_ticks;
        logic [7:0] reset_pulse_ticks;
    } t_cfg;

    typedef struct packed {
        logic  supply_enable;
        logic  reset_active;
        logic  led_lit;
        t_mode status_mode;
    } t_result;

endpackage

@@ rtl/atx_pbs_cfg.sv @@
// ----------------------------------------------------------------------------
// atx pbs configuration registers
// holds the six timing registers, written through the config channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atx_pbs_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [atx_pbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [atx_pbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output atx_pbs_pkg::t_cfg                   o_cfg
);
    import atx_pbs_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_good_delay   <= RST_POWER_GOOD_DELAY;
            r_cfg.hold_limit         <= RST_HOLD_LIMIT;
            r_cfg.blink_period       <= RST_BLINK_PERIOD;
            r_cfg.reset_blink_period <= RST_RESET_BLINK_PERIOD;
            r_cfg.reset_blink_ticks  <= RST_RESET_BLINK_TICKS;
            r_cfg.reset_pulse_ticks  <= RST_RESET_PULSE_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_POWER_GOOD_DELAY:   r_cfg.power_good_delay   <= i_cfg_data[7:0];
                REG_HOLD_LIMIT:         r_cfg.hold_limit         <= i_cfg_data[9:0];
                REG_BLINK_PERIOD:       r_cfg.blink_period       <= i_cfg_data[7:0];
                REG_RESET_BLINK_PERIOD: r_cfg.reset_blink_period <= i_cfg_data[7:0];
                REG_RESET_BLINK_TICKS:  r_cfg.reset_blink_ticks  <= i_cfg_data[7:0];
                REG_RESET_PULSE_TICKS:  r_cfg.reset_pulse_ticks  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/atx_pbs_core.sv @@
// ----------------------------------------------------------------------------
// atx pbs tick core
// sequencer state and the combinational next-state update for one tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atx_pbs_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_button_down,
    input  logic                    i_power_good,
    input  atx_pbs_pkg::t_cfg       i_cfg,
    output atx_pbs_pkg::t_result    o_res
);
    import atx_pbs_pkg::*;

    logic       r_first,  n_first;
    t_mode      r_mode,   n_mode;
    logic       r_led,    n_led;
    logic       r_enable, n_enable;
    logic       r_rst_line, n_rst_line;
    logic [7:0] r_settle, n_settle;
    logic [9:0] r_held,   n_held;
    logic [7:0] r_blink,  n_blink;
    logic [7:0] r_left,   n_left;
    logic       r_last,   n_last;

    logic [7:0]        thr;
    logic [8:0]        settle_inc;
    logic [8:0]        blink_inc;
    logic signed [9:0] limit;

    always_comb begin
        n_first    = 1'b0;
        n_mode     = r_mode;
        n_led      = r_led;
        n_enable   = r_enable;
        n_rst_line = r_rst_line;
        n_settle   = r_settle;
        n_held     = r_held;
        n_blink    = r_blink;
        n_left     = r_left;
        n_last     = r_last;
        thr        = i_cfg.blink_period;
        settle_inc = '0;
        blink_inc  = '0;
        limit      = $signed({2'b00, i_cfg.reset_blink_ticks})
                   - $signed({2'b00, i_cfg.reset_pulse_ticks});

        // first tick adopts mode from power-good
        if (r_first) begin
            n_settle   = '0;
            n_held     = '0;
            n_blink    = '0;
            n_left     = '0;
            n_last     = 1'b0;
            n_rst_line = 1'b0;
            if (i_power_good) begin
                n_mode   = MODE_ON;
                n_enable = 1'b1;
            end else begin
                n_mode   = MODE_OFF;
                n_enable = 1'b0;
            end
        end

        if (n_mode != MODE_OFF) begin
            settle_inc = {1'b0, n_settle} + 9'd1;
            if (settle_inc > {1'b0, i_cfg.power_good_delay}) begin
                settle_inc = {1'b0, i_cfg.power_good_delay};
            end
            n_settle = settle_inc[7:0];
        end

        if (n_settle >= i_cfg.power_good_delay) begin
            if (!i_power_good) begin
                n_mode   = MODE_OFF;
                n_enable = 1'b0;
            end else begin
                n_mode = MODE_ON;
            end
        end

        // reset blinking phase
        if (n_left != 8'd0 && n_mode != MODE_OFF) begin
            thr    = i_cfg.reset_blink_period;
            n_left = n_left - 8'd1;
            if ($signed({2'b00, n_left}) < limit) begin
                n_rst_line = 1'b0;
            end
            n_mode = (n_left == 8'd0) ? MODE_ON : MODE_FLASH;
        end else begin
            n_left     = '0;
            n_rst_line = 1'b0;
        end

        case (n_mode)
            MODE_OFF: n_led = 1'b0;
            MODE_ON:  n_led = 1'b1;
            MODE_FLASH: begin
                blink_inc = {1'b0, n_blink} + 9'd1;
                if (blink_inc > {1'b0, thr}) begin
                    n_led     = ~n_led;
                    blink_inc = '0;
                end
                n_blink = blink_inc[7:0];
            end
            default: begin
            end
        endcase

        if (i_button_down) begin
            if (n_held != HELD_MAX) begin
                n_held = n_held + 10'd1;
            end
            if (n_held > i_cfg.hold_limit && n_mode != MODE_OFF) begin
                n_mode   = MODE_OFF;
                n_enable = 1'b0;
            end else if (n_mode == MODE_OFF && !n_last) begin
                n_mode   = MODE_FLASH;
                n_enable = 1'b1;
                n_settle = '0;
                n_blink  = '0;
                n_left   = '0;
            end
        end else begin
            n_held = '0;
            if (n_last && n_mode != MODE_OFF) begin
                if (n_settle >= i_cfg.power_good_delay && n_left == 8'd0) begin
                    n_rst_line = 1'b1;
                    n_left     = i_cfg.reset_blink_ticks;
                    n_blink    = '0;
                end
            end
        end
        n_last = i_button_down;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= 1'b1;
            r_mode     <= MODE_OFF;
            r_led      <= 1'b0;
            r_enable   <= 1'b0;
            r_rst_line <= 1'b0;
            r_settle   <= '0;
            r_held     <= '0;
            r_blink    <= '0;
            r_left     <= '0;
            r_last     <= 1'b0;
        end else if (i_step) begin
            r_first    <= n_first;
            r_mode     <= n_mode;
            r_led      <= n_led;
            r_enable   <= n_enable;
            r_rst_line <= n_rst_line;
            r_settle   <= n_settle;
            r_held     <= n_held;
            r_blink    <= n_blink;
            r_left     <= n_left;
            r_last     <= n_last;
        end
    end

    assign o_res.supply_enable = n_enable;
    assign o_res.reset_active  = n_rst_line;
    assign o_res.led_lit       = n_led;
    assign o_res.status_mode   = n_mode;

endmodule

@@ rtl/atx_power_button_sequencer.sv @@
// ----------------------------------------------------------------------------
// atx power button sequencer
// Takes one tick per cycle and returns one result per tick: a tick enters an
// input register, then its state update runs in one pass through the counter
// compares of the tick core into the result register, so throughput is one
// tick per clock while the result side takes transfers. The result register
// lets a new tick enter while the previous result waits. Configuration writes
// are always ready and should be issued only while no tick is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atx_power_button_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_button_down,
    input  logic                                i_power_good,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_supply_enable,
    output logic                                o_reset_active,
    output logic                                o_led_lit,
    output logic [1:0]                          o_status_mode,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [atx_pbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [atx_pbs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import atx_pbs_pkg::*;

    t_cfg    cfg;
    t_result core_res;

    logic    r_in_valid;
    logic    r_in_button;
    logic    r_in_pg;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    atx_pbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    atx_pbs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (r_in_valid && advance),
        .i_button_down (r_in_button),
        .i_power_good  (r_in_pg),
        .i_cfg         (cfg),
        .o_res         (core_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_button <= i_button_down;
            r_in_pg     <= i_power_good;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_supply_enable = r_out.supply_enable;
    assign o_reset_active  = r_out.reset_active;
    assign o_led_lit       = r_out.led_lit;
    assign o_status_mode   = r_out.status_mode;

endmodule

@@ rtl/atx_pbs_checker.sv @@
// ----------------------------------------------------------------------------
// atx pbs port checker
// watches the top level ports for transfer and status consistency
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "atx_power_button_sequencer_macros.svh"

module atx_pbs_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic                                o_supply_enable,
    input  logic                                o_reset_active,
    input  logic                                o_led_lit,
    input  logic [1:0]                          o_status_mode
);
    import atx_pbs_pkg::*;

    logic       in_xfer;
    logic       out_held;
    logic [4:0] out_word;
    logic       off_shown;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_held  = o_out_valid && i_out_stall;
    assign out_word  = {o_supply_enable, o_reset_active, o_led_lit, o_status_mode};
    assign off_shown = o_out_valid && (o_status_mode == MODE_OFF);

    // stalled result stays put
    `ATX_PBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))

    // an accepted tick reaches the result side through the input and result registers when not stalled
    `ATX_PBS_ASSERT_NEXT(a_latency, i_clk, i_rst_n, in_xfer ##1 !i_out_stall, o_out_valid)

    // supply is never requested while the mode reads off
    `ATX_PBS_ASSERT_NOW(a_off_no_supply, i_clk, i_rst_n, off_shown, !o_supply_enable)

endmodule

bind atx_power_button_sequencer atx_pbs_checker u_atx_pbs_checker (.*);
